### rtl/ssrm_pkg.sv
package ssrm_pkg;

	// widest slot number and run length over the supported parameter ranges
	localparam int CMD_SLOT_W = 10;
	localparam int CMD_LEN_W  = 7;

	typedef struct packed {
		logic [CMD_SLOT_W-1:0] slot;
		logic [CMD_LEN_W-1:0]  count;
		logic                  dropped;
		logic                  bank;
	} merge_cmd_t;

	// offset of an entry inside one of two equal banks
	function automatic int bank_offset(input logic bank, input int idx, input int bank_size);
		return int'(bank) * bank_size + idx;
	endfunction

endpackage

### rtl/ssrm_in_if.sv
interface ssrm_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  gap_select;
	logic [3:0]  row_select;
	logic [31:0] pixel_index;
	logic        run_last;

	modport source (output valid, gap_select, row_select, pixel_index, run_last, input ready);
	modport sink (input valid, gap_select, row_select, pixel_index, run_last, output ready);
endinterface

### rtl/ssrm_out_if.sv
interface ssrm_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] merged_index;
	logic        merged_last;
	logic [5:0]  merged_length;
	logic        overflow;

	modport source (output valid, merged_index, merged_last, merged_length, overflow,
		input ready);
	modport sink (input valid, merged_index, merged_last, merged_length, overflow,
		output ready);
endinterface

### rtl/ssrm_ram.sv
module ssrm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/ssrm_queue.sv
module ssrm_queue
	import ssrm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  merge_cmd_t push_cmd,
	output logic       full,
	input  logic       pop,
	output merge_cmd_t head,
	output logic       nonempty
);

	merge_cmd_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'd2);
	assign nonempty = (count_q != 2'd0);
	assign head     = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

### rtl/ssrm_front.sv
module ssrm_front
	import ssrm_pkg::*;
#(
	parameter int GAP_COUNT    = 4,
	parameter int ROW_COUNT    = 16,
	parameter int ROW_CAPACITY = 32,
	localparam int LEN_W  = $clog2(ROW_CAPACITY + 1),
	localparam int RUN_AW = $clog2(2 * ROW_CAPACITY)
) (
	input  logic              clk,
	input  logic              arst_n,
	ssrm_in_if.sink           run,
	input  logic              clear_busy,
	input  logic              q_full,
	output logic              push,
	output merge_cmd_t        push_cmd,
	output logic              run_wr_en,
	output logic [RUN_AW-1:0] run_wr_addr,
	output logic [31:0]       run_wr_data
);

	logic [LEN_W-1:0] cnt_q;
	logic             drop_q;
	logic             bank_q;

	logic             accept;
	logic             has_room;
	logic [LEN_W-1:0] cnt_inc;
	logic             drop_nx;
	logic             in_range;

	assign run.ready = !clear_busy && !q_full;
	assign accept    = run.valid && run.ready;

	always_comb begin
		has_room = (cnt_q < LEN_W'(ROW_CAPACITY));
		cnt_inc  = has_room ? (cnt_q + LEN_W'(1)) : cnt_q;
		drop_nx  = drop_q || !has_room;
		in_range = (int'(run.gap_select) < GAP_COUNT) && (int'(run.row_select) < ROW_COUNT);

		run_wr_en   = accept && has_room;
		run_wr_addr = RUN_AW'(bank_offset(bank_q, int'(cnt_q), ROW_CAPACITY));
		run_wr_data = run.pixel_index;

		push             = accept && run.run_last && in_range;
		push_cmd.slot    = CMD_SLOT_W'(int'(run.gap_select) * ROW_COUNT + int'(run.row_select));
		push_cmd.count   = CMD_LEN_W'(cnt_inc);
		push_cmd.dropped = drop_nx;
		push_cmd.bank    = bank_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			drop_q <= 1'b0;
			bank_q <= 1'b0;
		end else if (accept) begin
			if (run.run_last) begin
				cnt_q  <= '0;
				drop_q <= 1'b0;
				if (in_range) begin
					bank_q <= ~bank_q;
				end
			end else begin
				cnt_q  <= cnt_inc;
				drop_q <= drop_nx;
			end
		end
	end

endmodule

### rtl/ssrm_back.sv
module ssrm_back
	import ssrm_pkg::*;
#(
	parameter int GAP_COUNT    = 4,
	parameter int ROW_COUNT    = 16,
	parameter int ROW_CAPACITY = 32,
	localparam int NUM_SLOTS = GAP_COUNT * ROW_COUNT,
	localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
	localparam int LEN_W     = $clog2(ROW_CAPACITY + 1),
	localparam int RUN_AW    = $clog2(2 * ROW_CAPACITY),
	localparam int LIST_AW   = $clog2(NUM_SLOTS * 2 * ROW_CAPACITY)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  merge_cmd_t        cmd,
	input  logic              cmd_valid,
	output logic              cmd_pop,
	output logic              clear_busy,
	output logic              run_rd_en,
	output logic [RUN_AW-1:0] run_rd_addr,
	input  logic [31:0]       run_rd_data,
	ssrm_out_if.source        merged
);

	typedef enum logic [1:0] {
		CLEAR,
		IDLE,
		LEN,
		MERGE
	} state_t;

	state_t            state_q;
	logic [SLOT_W-1:0] clr_q;
	logic [LEN_W-1:0]  old_len_q;
	logic              bank_q;
	logic [LEN_W-1:0]  total_q;
	logic              ovf_q;
	logic [LEN_W-1:0]  oi_q;
	logic [LEN_W-1:0]  ri_q;
	logic [LEN_W-1:0]  n_q;

	logic              out_valid_q;
	logic [31:0]       out_index_q;
	logic              out_last_q;
	logic [5:0]        out_length_q;
	logic              out_ovf_q;

	logic               sm_wr_en;
	logic [SLOT_W-1:0]  sm_wr_addr;
	logic [LEN_W:0]     sm_wr_data;
	logic               sm_rd_en;
	logic [LEN_W:0]     sm_rd_data;

	logic               lm_wr_en;
	logic [LIST_AW-1:0] lm_wr_addr;
	logic               lm_rd_en;
	logic [LIST_AW-1:0] lm_rd_addr;
	logic [31:0]        lm_rd_data;

	logic [SLOT_W-1:0] slot;
	logic [LEN_W-1:0]  run_cnt;
	logic [LEN_W-1:0]  old_len_d;
	logic              bank_d;
	logic [LEN_W:0]    sum_d;
	logic              over_d;
	logic [LEN_W-1:0]  total_d;
	logic              old_ok;
	logic              run_ok;
	logic              take_old;
	logic [31:0]       pick;
	logic              step;
	logic              fin;
	logic [LEN_W-1:0]  oi_nx;
	logic [LEN_W-1:0]  ri_nx;

	function automatic logic [LIST_AW-1:0] list_addr(input logic [SLOT_W-1:0] s,
		input logic b, input logic [LEN_W-1:0] i);
		return LIST_AW'((int'(s) * 2 + int'(b)) * ROW_CAPACITY + int'(i));
	endfunction

	ssrm_ram #(.WIDTH(LEN_W + 1), .DEPTH(NUM_SLOTS)) u_slot_ram (
		.clk     (clk),
		.wr_en   (sm_wr_en),
		.wr_addr (sm_wr_addr),
		.wr_data (sm_wr_data),
		.rd_en   (sm_rd_en),
		.rd_addr (slot),
		.rd_data (sm_rd_data)
	);

	ssrm_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS * 2 * ROW_CAPACITY)) u_list_ram (
		.clk     (clk),
		.wr_en   (lm_wr_en),
		.wr_addr (lm_wr_addr),
		.wr_data (pick),
		.rd_en   (lm_rd_en),
		.rd_addr (lm_rd_addr),
		.rd_data (lm_rd_data)
	);

	assign clear_busy           = (state_q == CLEAR);
	assign merged.valid         = out_valid_q;
	assign merged.merged_index  = out_index_q;
	assign merged.merged_last   = out_last_q;
	assign merged.merged_length = out_length_q;
	assign merged.overflow      = out_ovf_q;

	always_comb begin
		slot      = SLOT_W'(cmd.slot);
		run_cnt   = LEN_W'(cmd.count);
		old_len_d = sm_rd_data[LEN_W-1:0];
		bank_d    = sm_rd_data[LEN_W];
		sum_d     = {1'b0, old_len_d} + {1'b0, run_cnt};
		over_d    = (sum_d > (LEN_W + 1)'(ROW_CAPACITY));
		total_d   = over_d ? LEN_W'(ROW_CAPACITY) : sum_d[LEN_W-1:0];

		old_ok   = (oi_q < old_len_q);
		run_ok   = (ri_q < run_cnt);
		take_old = old_ok && (!run_ok || (lm_rd_data < run_rd_data));
		pick     = take_old ? lm_rd_data : run_rd_data;
		step     = (state_q == MERGE) && (!out_valid_q || merged.ready);
		fin      = step && ((n_q + LEN_W'(1)) == total_q);
		oi_nx    = oi_q + LEN_W'(1);
		ri_nx    = ri_q + LEN_W'(1);

		sm_wr_en   = (state_q == CLEAR) || fin;
		sm_wr_addr = (state_q == CLEAR) ? clr_q : slot;
		sm_wr_data = (state_q == CLEAR) ? '0 : {~bank_q, total_q};
		sm_rd_en   = (state_q == IDLE) && cmd_valid;

		lm_wr_en   = step;
		lm_wr_addr = list_addr(slot, ~bank_q, n_q);
		lm_rd_en   = (state_q == LEN) || (step && take_old && (oi_nx < old_len_q));
		lm_rd_addr = (state_q == LEN) ? list_addr(slot, bank_d, '0)
			: list_addr(slot, bank_q, oi_nx);

		run_rd_en   = (state_q == LEN) || (step && !take_old && (ri_nx < run_cnt));
		run_rd_addr = (state_q == LEN) ? RUN_AW'(bank_offset(cmd.bank, 0, ROW_CAPACITY))
			: RUN_AW'(bank_offset(cmd.bank, int'(ri_nx), ROW_CAPACITY));

		cmd_pop = fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= CLEAR;
			clr_q        <= '0;
			old_len_q    <= '0;
			bank_q       <= 1'b0;
			total_q      <= '0;
			ovf_q        <= 1'b0;
			oi_q         <= '0;
			ri_q         <= '0;
			n_q          <= '0;
			out_valid_q  <= 1'b0;
			out_index_q  <= '0;
			out_last_q   <= 1'b0;
			out_length_q <= '0;
			out_ovf_q    <= 1'b0;
		end else begin
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (merged.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				CLEAR: begin
					if (clr_q == SLOT_W'(NUM_SLOTS - 1)) begin
						state_q <= IDLE;
					end else begin
						clr_q <= clr_q + SLOT_W'(1);
					end
				end
				IDLE: begin
					if (cmd_valid) begin
						state_q <= LEN;
					end
				end
				LEN: begin
					old_len_q <= old_len_d;
					bank_q    <= bank_d;
					total_q   <= total_d;
					ovf_q     <= cmd.dropped || over_d;
					oi_q      <= '0;
					ri_q      <= '0;
					n_q       <= '0;
					state_q   <= MERGE;
				end
				MERGE: begin
					if (step) begin
						out_index_q  <= pick;
						out_last_q   <= fin;
						out_length_q <= 6'(total_q);
						out_ovf_q    <= ovf_q;
						n_q          <= n_q + LEN_W'(1);
						if (take_old) begin
							oi_q <= oi_nx;
						end else begin
							ri_q <= ri_nx;
						end
						if (fin) begin
							state_q <= IDLE;
						end
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/slotted_sorted_run_merge_top.sv
// Sorted run merge into a table of per-slot ascending lists, one list per
// (gap, row) slot of up to ROW_CAPACITY entries. After reset the slot length
// table is cleared slot by slot, during which no word is taken. Run words are
// taken one per cycle, unless the input stalls, into one of two run buffers.
// The word with run_last queues the merge if its slot is in range. The merge
// reads the slot length, then the list heads, then merges word by word, each
// word leaving as it is produced unless the output stalls. The merge
// alternates list banks, so it writes the new list while it reads the old one.
// While a merge runs, the next run is collected in the other buffer; after
// the clear, input stalls only while a finished run waits behind the merge.
module slotted_sorted_run_merge_top
	import ssrm_pkg::*;
#(
	parameter int GAP_COUNT    = 4,
	parameter int ROW_COUNT    = 16,
	parameter int ROW_CAPACITY = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	ssrm_in_if.sink    run,
	ssrm_out_if.source merged
);

	localparam int RUN_AW = $clog2(2 * ROW_CAPACITY);

	logic              clear_busy;
	logic              q_full;
	logic              push;
	merge_cmd_t        push_cmd;
	logic              pop;
	merge_cmd_t        head;
	logic              nonempty;
	logic              run_wr_en;
	logic [RUN_AW-1:0] run_wr_addr;
	logic [31:0]       run_wr_data;
	logic              run_rd_en;
	logic [RUN_AW-1:0] run_rd_addr;
	logic [31:0]       run_rd_data;

	ssrm_front #(
		.GAP_COUNT    (GAP_COUNT),
		.ROW_COUNT    (ROW_COUNT),
		.ROW_CAPACITY (ROW_CAPACITY)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.run         (run),
		.clear_busy  (clear_busy),
		.q_full      (q_full),
		.push        (push),
		.push_cmd    (push_cmd),
		.run_wr_en   (run_wr_en),
		.run_wr_addr (run_wr_addr),
		.run_wr_data (run_wr_data)
	);

	ssrm_ram #(.WIDTH(32), .DEPTH(2 * ROW_CAPACITY)) u_run_ram (
		.clk     (clk),
		.wr_en   (run_wr_en),
		.wr_addr (run_wr_addr),
		.wr_data (run_wr_data),
		.rd_en   (run_rd_en),
		.rd_addr (run_rd_addr),
		.rd_data (run_rd_data)
	);

	ssrm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.head     (head),
		.nonempty (nonempty)
	);

	ssrm_back #(
		.GAP_COUNT    (GAP_COUNT),
		.ROW_COUNT    (ROW_COUNT),
		.ROW_CAPACITY (ROW_CAPACITY)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (head),
		.cmd_valid   (nonempty),
		.cmd_pop     (pop),
		.clear_busy  (clear_busy),
		.run_rd_en   (run_rd_en),
		.run_rd_addr (run_rd_addr),
		.run_rd_data (run_rd_data),
		.merged      (merged)
	);

endmodule
